### rtl/hfe_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hfe_pkg
// Shared constants, tables and helper functions of the Hermite function
// evaluation unit.
// ----------------------------------------------------------------------------
package hfe_pkg;

	localparam int MAX_DEGREE = 63;
	localparam int FRAC_BITS  = 32;
	localparam int XBITS      = 24;
	localparam int CBITS      = 28;

	localparam int DEG_W   = 6;
	localparam int X_W     = 32;
	localparam int VAL_W   = 48;
	localparam int CFG_W   = 6;
	localparam int CIDX_W  = 1;

	localparam logic [CIDX_W-1:0] CFG_DEGREE  = 1'd0;
	localparam logic [CIDX_W-1:0] CFG_L2_MODE = 1'd1;

	localparam logic [63:0] VAL_LIM  = (64'd1 << 47) - 64'd1;
	localparam logic [63:0] TERM_LIM = 64'd1 << 61;

	localparam logic [31:0] LOG2E_Q28     = 32'd387270501;
	localparam logic [31:0] LN2_Q30       = 32'd744261118;
	localparam logic [31:0] INVQ4_2PI_Q30 = 32'd678195498;
	localparam logic [30:0] ONE_Q30       = 31'd1 << 30;
	localparam logic [63:0] Y_LIMIT       = 64'd64 << CBITS;
	localparam logic [7:0]  SH_BASE       = 8'(60 - FRAC_BITS);
	localparam logic [63:0] ONE_VAL       = 64'd1 << FRAC_BITS;
	localparam int          RECIP_SH      = 36;

	// Clamp selection of the shared multiplier.
	localparam logic [1:0] LIM_NONE = 2'd0;
	localparam logic [1:0] LIM_VAL  = 2'd1;
	localparam logic [1:0] LIM_TERM = 2'd2;

	typedef logic [31:0] ctab_t [64];
	typedef logic [63:0] rtab_t [16];

	typedef struct packed {
		logic [31:0] a;
		logic [63:0] b;
		logic        neg;
		logic [5:0]  sh;
		logic        rnd;
		logic [1:0]  lim;
	} mul_cmd_t;

	// Largest r with r*r*m <= n, found one bit at a time.
	function automatic logic [31:0] root_floor(logic [63:0] n, logic [7:0] m);
		logic [31:0]  r;
		logic [31:0]  trial;
		logic [127:0] sq;
		r = '0;
		for (int b = 31; b >= 0; b--) begin
			trial = r | (32'd1 << b);
			sq = 128'(trial) * 128'(trial) * 128'(m);
			if (sq <= 128'(n)) begin
				r = trial;
			end
		end
		return r;
	endfunction

	// floor(sqrt(i) * 2^28) for each order i.
	function automatic ctab_t build_sqrt_tab();
		ctab_t t;
		for (int i = 0; i < 64; i++) begin
			t[i] = root_floor(64'(i) << 56, 8'd1);
		end
		return t;
	endfunction

	// floor(2^28 / sqrt(i+1)) for each order i.
	function automatic ctab_t build_inv_tab();
		ctab_t t;
		for (int i = 0; i < 64; i++) begin
			t[i] = root_floor(64'd1 << 56, 8'(i + 1));
		end
		return t;
	endfunction

	// ceil(2^36 / k): the product with a dividend below 2^31, shifted right by
	// 36, gives the exact quotient by k for every k up to 15.
	function automatic rtab_t build_recip_tab();
		rtab_t t;
		t[0] = '0;
		for (int k = 1; k < 16; k++) begin
			t[k] = ((64'd1 << RECIP_SH) + 64'(k) - 64'd1) / 64'(k);
		end
		return t;
	endfunction

	localparam ctab_t SQRT_TAB  = build_sqrt_tab();
	localparam ctab_t INV_TAB   = build_inv_tab();
	localparam rtab_t RECIP_TAB = build_recip_tab();

	function automatic logic [63:0] abs64(logic signed [63:0] v);
		return v[63] ? 64'(-v) : 64'(v);
	endfunction

	function automatic mul_cmd_t mk_cmd(logic [31:0] a, logic [63:0] b, logic neg,
			logic [5:0] sh, logic rnd, logic [1:0] lim);
		mul_cmd_t c;
		c.a   = a;
		c.b   = b;
		c.neg = neg;
		c.sh  = sh;
		c.rnd = rnd;
		c.lim = lim;
		return c;
	endfunction

endpackage
`default_nettype wire

### rtl/hermite_function_eval_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hermite_function_eval_unit
// Evaluates orthonormal probabilists' Hermite values v0..vD of one sample.
// ----------------------------------------------------------------------------
// Usage: a sample on x_sample is taken at a clock edge where start is high and
// busy is low. The unit then emits the values of orders 0 to degree, one per
// result transaction, each shown for one cycle with result_valid high,
// together with order_index and last_value (high on the final order). The
// receiver cannot stall; results are simply presented in order.
// Configuration (cfg_we, cfg_index, cfg_data) writes degree (index 0) and
// l2_mode (index 1); write only while busy is low.
// Sequence: all products go through one 32x16 multiplier, which sums the
// four 16-bit chunks of its second operand, then rounds and clamps. v0 is
// emitted from S_EMIT0 straight after acceptance without L2 weight; in L2
// mode the Gaussian weight comes first, dominated by the fourteen Horner
// steps (a multiply, then a reciprocal multiply for the division by the term
// index), or is set to zero when the sample is too large for the weight. v1
// takes one multiply after v0, and each further order three multiplies. busy
// drops together with the last result. Reset clears the sequencer and the
// result strobe; degree returns to 8 and l2_mode to 0.
// ----------------------------------------------------------------------------
module hermite_function_eval_unit (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            start,
	output logic                                 busy,
	input  wire logic signed [hfe_pkg::X_W-1:0]  x_sample,
	input  wire logic                            cfg_we,
	input  wire logic [hfe_pkg::CIDX_W-1:0]      cfg_index,
	input  wire logic [hfe_pkg::CFG_W-1:0]       cfg_data,
	output logic                                 result_valid,
	output logic signed [hfe_pkg::VAL_W-1:0]     poly_value,
	output logic [hfe_pkg::DEG_W-1:0]            order_index,
	output logic                                 last_value
);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_MUL   = 4'd1;
	localparam logic [3:0] S_MFIN  = 4'd2;
	localparam logic [3:0] S_L2_Y  = 4'd3;
	localparam logic [3:0] S_L2_Z  = 4'd4;
	localparam logic [3:0] S_L2_T  = 4'd5;
	localparam logic [3:0] S_L2_H  = 4'd6;
	localparam logic [3:0] S_DIV   = 4'd7;
	localparam logic [3:0] S_L2_F  = 4'd8;
	localparam logic [3:0] S_EMIT0 = 4'd9;
	localparam logic [3:0] S_EMIT1 = 4'd10;
	localparam logic [3:0] S_T1    = 4'd11;
	localparam logic [3:0] S_T2    = 4'd12;
	localparam logic [3:0] S_NV    = 4'd13;

	logic [3:0] state_q;
	logic [3:0] ret_q;

	logic [hfe_pkg::DEG_W-1:0] degree_q;
	logic                      l2_mode_q;

	logic signed [hfe_pkg::X_W-1:0]   x_q;
	logic [hfe_pkg::DEG_W-1:0]        d_q;
	logic [hfe_pkg::DEG_W-1:0]        i_q;
	logic signed [hfe_pkg::VAL_W-1:0] vp_q;
	logic signed [hfe_pkg::VAL_W-1:0] vc_q;
	logic signed [63:0]               f_q;
	logic signed [63:0]               t1_q;

	// Shared multiplier
	hfe_pkg::mul_cmd_t cmd_q;
	logic [1:0]        chunk_q;
	logic [95:0]       acc_q;
	logic signed [63:0] res_q;

	// L2 weight working registers
	logic [6:0]  n_q;
	logic [29:0] t_q;
	logic [3:0]  k_q;

	logic [31:0] x_mag;
	logic [15:0] b_chunk;
	logic [47:0] part;
	logic [95:0] rnd_add;
	logic [95:0] shifted;
	logic [63:0] lim_val;
	logic [63:0] mag;
	logic [30:0] e_next;
	logic [7:0]  fsh;
	logic [63:0] fsum;
	logic [63:0] fval;
	logic signed [63:0] diff;
	logic [hfe_pkg::DEG_W-1:0] i_next;

	assign x_mag   = x_q[hfe_pkg::X_W-1] ? 32'(-x_q) : 32'(x_q);
	assign b_chunk = cmd_q.b[{chunk_q, 4'd0} +: 16];
	assign part    = 48'(cmd_q.a) * 48'(b_chunk);
	assign rnd_add = cmd_q.rnd ? (96'd1 << (cmd_q.sh - 6'd1)) : '0;
	assign shifted = (acc_q + rnd_add) >> cmd_q.sh;
	assign lim_val = (cmd_q.lim == hfe_pkg::LIM_VAL) ? hfe_pkg::VAL_LIM : hfe_pkg::TERM_LIM;

	always_comb begin
		mag = shifted[63:0];
		if (cmd_q.lim != hfe_pkg::LIM_NONE) begin
			if ((|shifted[95:64]) || (shifted[63:0] > lim_val)) begin
				mag = lim_val;
			end
		end
	end

	assign e_next = hfe_pkg::ONE_Q30 - res_q[30:0];
	assign fsh    = hfe_pkg::SH_BASE + {1'b0, n_q};
	assign fsum   = res_q + (64'd1 << (fsh - 8'd1));
	assign fval   = (fsh >= 8'd64) ? 64'd0 : (fsum >> fsh);
	assign diff   = t1_q - res_q;
	assign i_next = i_q + 6'd1;

	assign busy = (state_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			degree_q  <= 6'd8;
			l2_mode_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				hfe_pkg::CFG_DEGREE:  degree_q  <= cfg_data;
				hfe_pkg::CFG_L2_MODE: l2_mode_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			ret_q        <= S_IDLE;
			result_valid <= 1'b0;
			vp_q         <= '0;
			vc_q         <= '0;
		end else begin
			result_valid <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						x_q <= x_sample;
						d_q <= (degree_q > 6'(hfe_pkg::MAX_DEGREE)) ?
							6'(hfe_pkg::MAX_DEGREE) : degree_q;
						if (l2_mode_q) begin
							cmd_q <= hfe_pkg::mk_cmd(x_sample[31] ? 32'(-x_sample) :
								32'(x_sample), {32'd0, x_sample[31] ? 32'(-x_sample) :
								32'(x_sample)}, 1'b0, 6'd22, 1'b1, hfe_pkg::LIM_NONE);
							acc_q   <= '0;
							chunk_q <= '0;
							ret_q   <= S_L2_Y;
							state_q <= S_MUL;
						end else begin
							f_q     <= hfe_pkg::ONE_VAL;
							state_q <= S_EMIT0;
						end
					end
				end
				S_MUL: begin
					acc_q   <= acc_q + ({48'd0, part} << {chunk_q, 4'd0});
					chunk_q <= chunk_q + 2'd1;
					if (chunk_q == 2'd3) begin
						state_q <= S_MFIN;
					end
				end
				S_MFIN: begin
					res_q   <= cmd_q.neg ? -$signed(mag) : $signed(mag);
					state_q <= ret_q;
				end
				S_L2_Y: begin
					if (64'(res_q) >= hfe_pkg::Y_LIMIT) begin
						f_q     <= '0;
						state_q <= S_EMIT0;
					end else begin
						cmd_q <= hfe_pkg::mk_cmd(hfe_pkg::LOG2E_Q28, 64'(res_q), 1'b0,
							6'(hfe_pkg::CBITS), 1'b1, hfe_pkg::LIM_NONE);
						acc_q   <= '0;
						chunk_q <= '0;
						ret_q   <= S_L2_Z;
						state_q <= S_MUL;
					end
				end
				S_L2_Z: begin
					n_q   <= res_q[34:28];
					cmd_q <= hfe_pkg::mk_cmd(hfe_pkg::LN2_Q30, {36'd0, res_q[27:0]}, 1'b0,
						6'(hfe_pkg::CBITS), 1'b0, hfe_pkg::LIM_NONE);
					acc_q   <= '0;
					chunk_q <= '0;
					ret_q   <= S_L2_T;
					state_q <= S_MUL;
				end
				S_L2_T: begin
					t_q   <= res_q[29:0];
					k_q   <= 4'd14;
					cmd_q <= hfe_pkg::mk_cmd({2'd0, res_q[29:0]}, 64'(hfe_pkg::ONE_Q30),
						1'b0, 6'd30, 1'b0, hfe_pkg::LIM_NONE);
					acc_q   <= '0;
					chunk_q <= '0;
					ret_q   <= S_L2_H;
					state_q <= S_MUL;
				end
				S_L2_H: begin
					// Division by the Horner term index as a reciprocal product.
					cmd_q <= hfe_pkg::mk_cmd({1'b0, res_q[30:0]}, hfe_pkg::RECIP_TAB[k_q],
						1'b0, 6'(hfe_pkg::RECIP_SH), 1'b0, hfe_pkg::LIM_NONE);
					acc_q   <= '0;
					chunk_q <= '0;
					ret_q   <= S_DIV;
					state_q <= S_MUL;
				end
				S_DIV: begin
					acc_q   <= '0;
					chunk_q <= '0;
					state_q <= S_MUL;
					if (k_q == 4'd1) begin
						cmd_q <= hfe_pkg::mk_cmd(hfe_pkg::INVQ4_2PI_Q30, 64'(e_next),
							1'b0, 6'd0, 1'b0, hfe_pkg::LIM_NONE);
						ret_q <= S_L2_F;
					end else begin
						k_q   <= k_q - 4'd1;
						cmd_q <= hfe_pkg::mk_cmd({2'd0, t_q}, 64'(e_next),
							1'b0, 6'd30, 1'b0, hfe_pkg::LIM_NONE);
						ret_q <= S_L2_H;
					end
				end
				S_L2_F: begin
					f_q     <= $signed(fval);
					state_q <= S_EMIT0;
				end
				S_EMIT0: begin
					result_valid <= 1'b1;
					poly_value   <= (64'(f_q) > hfe_pkg::VAL_LIM) ?
						48'(hfe_pkg::VAL_LIM) : 48'(f_q);
					order_index  <= '0;
					last_value   <= (d_q == 6'd0);
					vp_q         <= '0;
					vc_q         <= (64'(f_q) > hfe_pkg::VAL_LIM) ?
						48'(hfe_pkg::VAL_LIM) : 48'(f_q);
					if (d_q == 6'd0) begin
						state_q <= S_IDLE;
					end else begin
						cmd_q <= hfe_pkg::mk_cmd(x_mag, (64'(f_q) > hfe_pkg::VAL_LIM) ?
							hfe_pkg::VAL_LIM : 64'(f_q), x_q[31],
							6'(hfe_pkg::XBITS), 1'b1, hfe_pkg::LIM_VAL);
						acc_q   <= '0;
						chunk_q <= '0;
						ret_q   <= S_EMIT1;
						state_q <= S_MUL;
					end
				end
				S_EMIT1, S_NV: begin
					result_valid <= 1'b1;
					poly_value   <= res_q[hfe_pkg::VAL_W-1:0];
					vp_q         <= vc_q;
					vc_q         <= res_q[hfe_pkg::VAL_W-1:0];
					if (state_q == S_EMIT1) begin
						order_index <= 6'd1;
						last_value  <= (d_q == 6'd1);
						i_q         <= 6'd1;
					end else begin
						order_index <= i_next;
						last_value  <= (i_next == d_q);
						i_q         <= i_next;
					end
					if (((state_q == S_EMIT1) && (d_q == 6'd1)) ||
							((state_q == S_NV) && (i_next == d_q))) begin
						state_q <= S_IDLE;
					end else begin
						cmd_q <= hfe_pkg::mk_cmd(x_mag, hfe_pkg::abs64(res_q),
							x_q[31] ^ res_q[63], 6'(hfe_pkg::XBITS), 1'b1,
							hfe_pkg::LIM_TERM);
						acc_q   <= '0;
						chunk_q <= '0;
						ret_q   <= S_T1;
						state_q <= S_MUL;
					end
				end
				S_T1: begin
					t1_q  <= res_q;
					cmd_q <= hfe_pkg::mk_cmd(hfe_pkg::SQRT_TAB[i_q],
						hfe_pkg::abs64(64'(vp_q)), vp_q[hfe_pkg::VAL_W-1],
						6'(hfe_pkg::CBITS), 1'b1, hfe_pkg::LIM_TERM);
					acc_q   <= '0;
					chunk_q <= '0;
					ret_q   <= S_T2;
					state_q <= S_MUL;
				end
				S_T2: begin
					cmd_q <= hfe_pkg::mk_cmd(hfe_pkg::INV_TAB[i_q], hfe_pkg::abs64(diff),
						diff[63], 6'(hfe_pkg::CBITS), 1'b1, hfe_pkg::LIM_VAL);
					acc_q   <= '0;
					chunk_q <= '0;
					ret_q   <= S_NV;
					state_q <= S_MUL;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// The final result of a sample and the return to idle coincide.
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && last_value |-> !busy)
		else $error("last result while still busy");

	a_mid_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !last_value |-> busy)
		else $error("non-final result but sequencer idle");

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted sample did not start the sequencer");

	a_order_step: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (order_index != 6'd0) |-> !$past(result_valid))
		else $error("orders above zero must be spaced apart");

endmodule
`default_nettype wire
